/* rtl/core/tw2s_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tw2s_pkg;

   localparam int TimeW  = 40;
   localparam int IntvW  = 32;
   localparam int CountW = 25;
   localparam int QuotW  = 41;
   localparam int IdxW   = 42;

   localparam logic [1:0] MODE_CLAMP = 2'd2;
   localparam logic [1:0] MODE_PAD   = 2'd3;

   localparam logic [1:0] CSR_MODE  = 2'd0;
   localparam logic [1:0] CSR_BEGIN = 2'd1;
   localparam logic [1:0] CSR_END   = 2'd2;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_EMPTY  = 3'd1;
   localparam logic [2:0] ST_AFTER  = 3'd2;
   localparam logic [2:0] ST_BEFORE = 3'd3;
   localparam logic [2:0] ST_EARLY  = 3'd4;
   localparam logic [2:0] ST_LATE   = 3'd5;
   localparam logic [2:0] ST_BOTH   = 3'd6;

   // per-item data that rides beside the dividers
   typedef struct packed {
      logic              valid;
      logic [1:0]        mode;
      logic              empty;
      logic [CountW-1:0] npts;
   } tw2s_side_type;

endpackage
`default_nettype wire

/* rtl/core/tw2s_rdiv.sv */
`timescale 1ns / 1ps
`default_nettype none
module tw2s_rdiv (
   input  wire logic                               clock,
   input  wire logic signed [tw2s_pkg::TimeW-1:0]  t,
   input  wire logic        [tw2s_pkg::IntvW-1:0]  d,
   output logic signed      [tw2s_pkg::QuotW-1:0]  q
);
   import tw2s_pkg::*;

   localparam int NumW = QuotW;
   localparam int DenW = IntvW + 1;

   logic [IntvW-1:0] dfix;
   logic [TimeW-1:0] mag;
   logic             neg_ff [NumW+1];
   logic [NumW-1:0]  nq_ff  [NumW+1];
   logic [DenW-1:0]  den_ff [NumW+1];
   logic [DenW-1:0]  rem_ff [NumW+1];
   logic signed [QuotW-1:0] q_ff;

   // take magnitude, form 2|t|+d over 2d
   always_comb begin
      dfix = (d == '0) ? IntvW'(1) : d;
      mag  = t[TimeW-1] ? TimeW'(-t) : TimeW'(t);
   end

   always_ff @(posedge clock) begin
      neg_ff[0] <= t[TimeW-1];
      nq_ff[0]  <= NumW'({mag, 1'b0}) + NumW'(dfix);
      den_ff[0] <= {dfix, 1'b0};
      rem_ff[0] <= '0;
   end

   // one quotient bit per stage
   for (genvar k = 0; k < NumW; k++) begin : g_stage
      logic [DenW:0]   trial;
      logic            take;
      logic [DenW-1:0] rem_in;
      always_comb begin
         trial  = {rem_ff[k], nq_ff[k][NumW-1]};
         take   = trial >= {1'b0, den_ff[k]};
         rem_in = take ? DenW'(trial - {1'b0, den_ff[k]}) : trial[DenW-1:0];
      end
      always_ff @(posedge clock) begin
         neg_ff[k+1] <= neg_ff[k];
         den_ff[k+1] <= den_ff[k];
         rem_ff[k+1] <= rem_in;
         nq_ff[k+1]  <= {nq_ff[k][NumW-2:0], take};
      end
   end

   // apply sign
   always_ff @(posedge clock) begin
      q_ff <= neg_ff[NumW] ? -$signed(nq_ff[NumW]) : $signed(nq_ff[NumW]);
   end

   assign q = q_ff;
endmodule
`default_nettype wire

/* rtl/core/tw2s_check.sv */
`timescale 1ns / 1ps
`default_nettype none
module tw2s_check (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tw2s_pkg::tw2s_side_type           side,
   input  wire logic signed [tw2s_pkg::QuotW-1:0] rb,
   input  wire logic signed [tw2s_pkg::QuotW-1:0] rs,
   input  wire logic signed [tw2s_pkg::QuotW-1:0] re,
   output logic                                   rsp_valid,
   output logic signed [tw2s_pkg::IdxW-1:0]       rsp_first_index,
   output logic signed [tw2s_pkg::IdxW-1:0]       rsp_last_index,
   output logic        [tw2s_pkg::IdxW-1:0]       rsp_fill_before,
   output logic        [tw2s_pkg::IdxW-1:0]       rsp_fill_after,
   output logic        [tw2s_pkg::IdxW-1:0]       rsp_out_length,
   output logic        [2:0]                      rsp_status
);
   import tw2s_pkg::*;

   localparam int WideW = IdxW + 1;
   localparam logic signed [WideW-1:0] Lim = WideW'(64'sd1 <<< (IdxW - 2));

   tw2s_side_type            a_side_ff;
   logic                     b_valid_ff;
   logic signed [IdxW-1:0]   a_ns_ff, a_ne_ff, b_ns_ff, b_ne_ff;
   logic signed [WideW-1:0]  b_fb_ff, b_fe_ff;
   logic [2:0]               b_st_ff;
   logic                     c_valid_ff;
   logic signed [IdxW-1:0]   c_ns_ff, c_ne_ff;
   logic [IdxW-1:0]          c_fb_ff, c_fe_ff, c_len_ff;
   logic [2:0]               c_st_ff;

   function automatic logic signed [IdxW-1:0] sat_idx(input logic signed [WideW-1:0] v);
      logic signed [IdxW-1:0] r;
      if (v > Lim) r = IdxW'(Lim);
      else if (v < -Lim) r = IdxW'(-Lim);
      else r = v[IdxW-1:0];
      return r;
   endfunction

   logic signed [WideW-1:0] ns_raw, ne_raw;
   always_comb begin
      ns_raw = WideW'(rs) - WideW'(rb) + WideW'(1);
      ne_raw = WideW'(re) - WideW'(rb) + WideW'(1);
   end

   // stage a: index and saturation
   always_ff @(posedge clock) begin
      if (reset) a_side_ff.valid <= 1'b0;
      else a_side_ff.valid <= side.valid;
      a_side_ff.mode  <= side.mode;
      a_side_ff.empty <= side.empty;
      a_side_ff.npts  <= side.npts;
      a_ns_ff <= sat_idx(ns_raw);
      a_ne_ff <= sat_idx(ne_raw);
   end

   // stage b: window against data bounds
   logic signed [IdxW-1:0]  npts, ns_in, ne_in;
   logic signed [WideW-1:0] fb_in, fe_in, span;
   logic [2:0]              st_in;
   logic                    pad_en, clamp_en, done;
   always_comb begin
      npts     = IdxW'($signed({1'b0, a_side_ff.npts}));
      pad_en   = a_side_ff.mode == MODE_PAD;
      clamp_en = a_side_ff.mode == MODE_CLAMP;
      span  = WideW'(a_ne_ff) - WideW'(a_ns_ff) + WideW'(1);
      ns_in = a_ns_ff;
      ne_in = a_ne_ff;
      fb_in = '0;
      fe_in = '0;
      st_in = ST_OK;
      done  = 1'b0;
      if (a_side_ff.empty) begin
         st_in = ST_EMPTY;
      end else if (a_ns_ff > npts) begin
         if (pad_en) fe_in = span;
         else st_in = ST_AFTER;
      end else if (a_ne_ff < IdxW'(1)) begin
         if (pad_en) fb_in = span;
         else st_in = ST_BEFORE;
      end else begin
         if (a_ns_ff < IdxW'(1)) begin
            if (pad_en) begin
               fb_in = WideW'(1) - WideW'(a_ns_ff);
            end else if (clamp_en) begin
               st_in = ST_EARLY;
               ns_in = IdxW'(1);
            end else begin
               st_in = ST_EARLY;
               done  = 1'b1;
            end
         end
         if (!done && a_ne_ff > npts) begin
            if (pad_en) begin
               fe_in = WideW'(a_ne_ff) - WideW'(npts);
            end else if (clamp_en) begin
               st_in = (st_in == ST_EARLY) ? ST_BOTH : ST_LATE;
               ne_in = npts;
            end else begin
               st_in = ST_LATE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) b_valid_ff <= 1'b0;
      else b_valid_ff <= a_side_ff.valid;
      b_ns_ff <= ns_in;
      b_ne_ff <= ne_in;
      b_fb_ff <= fb_in;
      b_fe_ff <= fe_in;
      b_st_ff <= st_in;
   end

   // stage c: length and floors
   logic signed [WideW-1:0] len;
   always_comb len = WideW'(b_ne_ff) - WideW'(b_ns_ff) + WideW'(1);

   always_ff @(posedge clock) begin
      if (reset) c_valid_ff <= 1'b0;
      else c_valid_ff <= b_valid_ff;
      c_ns_ff  <= b_ns_ff;
      c_ne_ff  <= b_ne_ff;
      c_fb_ff  <= b_fb_ff[WideW-1] ? '0 : b_fb_ff[IdxW-1:0];
      c_fe_ff  <= b_fe_ff[WideW-1] ? '0 : b_fe_ff[IdxW-1:0];
      c_len_ff <= len[WideW-1] ? '0 : len[IdxW-1:0];
      c_st_ff  <= b_st_ff;
   end

   assign rsp_valid       = c_valid_ff;
   assign rsp_first_index = c_ns_ff;
   assign rsp_last_index  = c_ne_ff;
   assign rsp_fill_before = c_fb_ff;
   assign rsp_fill_after  = c_fe_ff;
   assign rsp_out_length  = c_len_ff;
   assign rsp_status      = c_st_ff;
endmodule
`default_nettype wire

/* rtl/core/time_window_to_sample_range.sv */
`timescale 1ns / 1ps
`default_nettype none
// Maps the configured cut window onto 1-based sample indices of each trace
// header word. A word is taken in every clock cycle (busy stays low) and its
// result leaves with rsp_valid high for one cycle; results come out in order
// and the receiver cannot stall them. Each word passes through three
// rounding dividers that resolve one quotient bit per stage over 41 stages,
// plus operand setup, sign, index, bounds check and length stages.
// Write the cut registers only while no word is in flight.
module time_window_to_sample_range #(
   parameter longint MAX_SAMPLES = 16777216
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic signed [tw2s_pkg::TimeW-1:0]     req_trace_begin,
   input  wire logic        [tw2s_pkg::IntvW-1:0]     req_sample_interval,
   input  wire logic        [tw2s_pkg::CountW-1:0]    req_sample_count,
   output logic                                       rsp_valid,
   output logic signed [tw2s_pkg::IdxW-1:0]           rsp_first_index,
   output logic signed [tw2s_pkg::IdxW-1:0]           rsp_last_index,
   output logic        [tw2s_pkg::IdxW-1:0]           rsp_fill_before,
   output logic        [tw2s_pkg::IdxW-1:0]           rsp_fill_after,
   output logic        [tw2s_pkg::IdxW-1:0]           rsp_out_length,
   output logic        [2:0]                          rsp_status,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic        [1:0]                     csr_index,
   input  wire logic        [tw2s_pkg::TimeW-1:0]     csr_data
);
   import tw2s_pkg::*;

   localparam int DivLat = QuotW + 2;
   localparam logic [32:0] MaxCnt = 33'(MAX_SAMPLES);

   logic [1:0]              mode_ff;
   logic signed [TimeW-1:0] begin_ff, end_ff;
   tw2s_side_type           side_ff [DivLat];
   tw2s_side_type           side_in;
   logic signed [QuotW-1:0] rb, rs, re;
   logic                    accept;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // hold the cut registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 2'd1;
         begin_ff <= '0;
         end_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODE:  mode_ff  <= csr_data[1:0];
            CSR_BEGIN: begin_ff <= $signed(csr_data);
            CSR_END:   end_ff   <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // capture per-word side data
   always_comb begin
      side_in.valid = accept;
      side_in.mode  = mode_ff;
      side_in.empty = begin_ff >= end_ff;
      side_in.npts  = (33'(req_sample_count) > MaxCnt) ?
                      CountW'(MaxCnt) : req_sample_count;
   end

   // advance side data beside the dividers
   always_ff @(posedge clock) begin
      if (reset) side_ff[0].valid <= 1'b0;
      else side_ff[0].valid <= side_in.valid;
      side_ff[0].mode  <= side_in.mode;
      side_ff[0].empty <= side_in.empty;
      side_ff[0].npts  <= side_in.npts;
   end
   for (genvar k = 1; k < DivLat; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) side_ff[k].valid <= 1'b0;
         else side_ff[k].valid <= side_ff[k-1].valid;
         side_ff[k].mode  <= side_ff[k-1].mode;
         side_ff[k].empty <= side_ff[k-1].empty;
         side_ff[k].npts  <= side_ff[k-1].npts;
      end
   end

   tw2s_rdiv u_div_b (.clock(clock), .t(req_trace_begin), .d(req_sample_interval), .q(rb));
   tw2s_rdiv u_div_s (.clock(clock), .t(begin_ff), .d(req_sample_interval), .q(rs));
   tw2s_rdiv u_div_e (.clock(clock), .t(end_ff), .d(req_sample_interval), .q(re));

   tw2s_check u_check (
      .clock(clock), .reset(reset), .side(side_ff[DivLat-1]),
      .rb(rb), .rs(rs), .re(re),
      .rsp_valid(rsp_valid), .rsp_first_index(rsp_first_index),
      .rsp_last_index(rsp_last_index), .rsp_fill_before(rsp_fill_before),
      .rsp_fill_after(rsp_fill_after), .rsp_out_length(rsp_out_length),
      .rsp_status(rsp_status)
   );

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("result right after reset");

   a_err_no_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_fill_before == '0 && rsp_fill_after == '0)
      else $error("fill reported with an error status");

   a_clamp_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BOTH) |-> rsp_first_index == IdxW'(1))
      else $error("clamped window does not start at one");

endmodule
`default_nettype wire
